### design/bmcs_pkg.sv
// shared types and constants for the best match config selector
`default_nettype none

package bmcs_pkg;

  localparam int CHAN_W  = 6;   // candidate channel field width
  localparam int WANT_W  = 7;   // desired channel register width, signed
  localparam int IDX_W   = 8;   // reported list position width
  localparam int MISS_W  = 3;   // missing buffer count width
  localparam int COLOR_W = 12;  // color score width
  localparam int EXTRA_W = 13;  // extra score width
  localparam int CFG_IDX_W = 3;

  localparam logic [COLOR_W-1:0] COLOR_MAX = {COLOR_W{1'b1}};
  localparam logic [EXTRA_W-1:0] EXTRA_MAX = {EXTRA_W{1'b1}};

  // don't-care code of a desired channel register
  localparam logic signed [WANT_W-1:0] DONT_CARE = -7'sd1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WANT_DOUBLE_BUFFER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WANT_RED           = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WANT_GREEN         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WANT_BLUE          = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WANT_ALPHA         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WANT_DEPTH         = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WANT_STENCIL       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_WANT_SAMPLES       = 3'd7;

  // one candidate word as held in the input register
  typedef struct packed {
    logic              has_double_buffer;
    logic [CHAN_W-1:0] has_red;
    logic [CHAN_W-1:0] has_green;
    logic [CHAN_W-1:0] has_blue;
    logic [CHAN_W-1:0] has_alpha;
    logic [CHAN_W-1:0] has_depth;
    logic [CHAN_W-1:0] has_stencil;
    logic [CHAN_W-1:0] has_samples;
    logic              last_candidate;
  } cand_t;

endpackage

`default_nettype wire

### design/bmcs_cand_if.sv
// candidate word channel
`default_nettype none

interface bmcs_cand_if
  import bmcs_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              has_double_buffer;
  logic [CHAN_W-1:0] has_red;
  logic [CHAN_W-1:0] has_green;
  logic [CHAN_W-1:0] has_blue;
  logic [CHAN_W-1:0] has_alpha;
  logic [CHAN_W-1:0] has_depth;
  logic [CHAN_W-1:0] has_stencil;
  logic [CHAN_W-1:0] has_samples;
  logic              last_candidate;

  modport source (
    output valid, has_double_buffer, has_red, has_green, has_blue,
           has_alpha, has_depth, has_stencil, has_samples, last_candidate,
    input  ready
  );

  modport sink (
    input  valid, has_double_buffer, has_red, has_green, has_blue,
           has_alpha, has_depth, has_stencil, has_samples, last_candidate,
    output ready
  );
endinterface

`default_nettype wire

### design/bmcs_result_if.sv
// result word channel
`default_nettype none

interface bmcs_result_if
  import bmcs_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               found;
  logic [IDX_W-1:0]   best_index;
  logic [MISS_W-1:0]  best_missing;
  logic [COLOR_W-1:0] best_color_score;
  logic [EXTRA_W-1:0] best_extra_score;

  modport source (
    output valid, found, best_index, best_missing, best_color_score,
           best_extra_score,
    input  ready
  );

  modport sink (
    input  valid, found, best_index, best_missing, best_color_score,
           best_extra_score,
    output ready
  );
endinterface

`default_nettype wire

### design/bmcs_cfg_if.sv
// configuration write channel
`default_nettype none

interface bmcs_cfg_if
  import bmcs_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [WANT_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### design/best_match_config_selector.sv
// best match config selector: scores a candidate list against a desired config
`default_nettype none

// Picks the candidate buffer configuration closest to the desired one held in
// the want_* registers (-1 = don't care). Candidates arrive one word per cycle
// and the block sustains one candidate per clock, except that a list's last
// candidate waits while an earlier result is still untaken. Each accepted word
// is held in the input register, scored there by one stage of small squares
// and a compare against the running best, and the final candidate's result
// word is then registered in the output register. The output register lets
// the next list start while a result still waits to be taken. Candidates whose
// double-buffer flag differs are skipped; the rest are ranked by missing
// required buffers, then color score, then extra score, ties keeping the
// earlier one. Candidates at positions MAX_CANDIDATES and beyond are ignored.
// Configuration writes are taken at any time but must only be made while the
// block holds no unfinished list.
module best_match_config_selector
  import bmcs_pkg::*;
#(
  parameter int MAX_CANDIDATES = 256
) (
  input  wire logic      clk,
  input  wire logic      rst,
  bmcs_cand_if.sink      cand,
  bmcs_result_if.source  result,
  bmcs_cfg_if.sink       cfg
);

  // counter holds MAX_CANDIDATES itself so it can stop there
  localparam int CNT_W = $clog2(MAX_CANDIDATES + 1);
  localparam int POS_W = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_CANDIDATES);

  // squared difference of one channel, zero when don't care
  function automatic logic [13:0] sq_term(input logic signed [WANT_W-1:0] want,
                                          input logic [CHAN_W-1:0] has);
    logic signed [7:0]  d;
    logic signed [15:0] p;
    d = {want[WANT_W-1], want} - $signed({2'b00, has});
    p = d * d;
    if (want == DONT_CARE) begin
      return 14'd0;
    end
    return p[13:0];
  endfunction

  // required buffer that the candidate lacks
  function automatic logic lacks(input logic signed [WANT_W-1:0] want,
                                 input logic [CHAN_W-1:0] has);
    return (want > 7'sd0) && (has == '0);
  endfunction

  // configuration registers
  logic                     want_double_buffer;
  logic signed [WANT_W-1:0] want_red;
  logic signed [WANT_W-1:0] want_green;
  logic signed [WANT_W-1:0] want_blue;
  logic signed [WANT_W-1:0] want_alpha;
  logic signed [WANT_W-1:0] want_depth;
  logic signed [WANT_W-1:0] want_stencil;
  logic signed [WANT_W-1:0] want_samples;

  // input register
  logic  s1_valid;
  cand_t s1;

  // search state
  logic [CNT_W-1:0]   item_position;
  logic               have_best;
  logic [POS_W-1:0]   best_position;
  logic [MISS_W-1:0]  fewest_missing_count;
  logic [COLOR_W-1:0] least_color_score;
  logic [EXTRA_W-1:0] least_extra_score;

  // output register
  logic               out_valid;
  logic               out_found;
  logic [IDX_W-1:0]   out_index;
  logic [MISS_W-1:0]  out_missing;
  logic [COLOR_W-1:0] out_color;
  logic [EXTRA_W-1:0] out_extra;

  // scoring stage
  logic               out_free;
  logic               s1_go;
  logic               in_range;
  logic               eligible;
  logic [MISS_W-1:0]  missing;
  logic [15:0]        color_sum;
  logic [16:0]        extra_sum;
  logic [COLOR_W-1:0] color;
  logic [EXTRA_W-1:0] extra;
  logic               better;
  logic               take;

  logic               have_best_next;
  logic [POS_W-1:0]   best_position_next;
  logic [MISS_W-1:0]  fewest_missing_count_next;
  logic [COLOR_W-1:0] least_color_score_next;
  logic [EXTRA_W-1:0] least_extra_score_next;
  logic [POS_W+IDX_W-1:0] pos_wide;

  // handshakes
  assign out_free   = !out_valid || result.ready;
  assign s1_go      = s1_valid && (!s1.last_candidate || out_free);
  assign cand.ready = !s1_valid || s1_go;
  assign cfg.ready  = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      want_double_buffer <= 1'b1;
      want_red           <= DONT_CARE;
      want_green         <= DONT_CARE;
      want_blue          <= DONT_CARE;
      want_alpha         <= DONT_CARE;
      want_depth         <= DONT_CARE;
      want_stencil       <= DONT_CARE;
      want_samples       <= DONT_CARE;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_WANT_DOUBLE_BUFFER: want_double_buffer <= cfg.data[0];
        REG_WANT_RED:           want_red           <= cfg.data;
        REG_WANT_GREEN:         want_green         <= cfg.data;
        REG_WANT_BLUE:          want_blue          <= cfg.data;
        REG_WANT_ALPHA:         want_alpha         <= cfg.data;
        REG_WANT_DEPTH:         want_depth         <= cfg.data;
        REG_WANT_STENCIL:       want_stencil       <= cfg.data;
        REG_WANT_SAMPLES:       want_samples       <= cfg.data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cand.ready) begin
      s1_valid <= cand.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cand.valid && cand.ready) begin
      s1.has_double_buffer <= cand.has_double_buffer;
      s1.has_red           <= cand.has_red;
      s1.has_green         <= cand.has_green;
      s1.has_blue          <= cand.has_blue;
      s1.has_alpha         <= cand.has_alpha;
      s1.has_depth         <= cand.has_depth;
      s1.has_stencil       <= cand.has_stencil;
      s1.has_samples       <= cand.has_samples;
      s1.last_candidate    <= cand.last_candidate;
    end
  end

  // score the held candidate
  always_comb begin
    in_range = item_position < CNT_LIMIT;
    eligible = in_range && (s1.has_double_buffer == want_double_buffer);

    missing = MISS_W'(lacks(want_alpha, s1.has_alpha))
            + MISS_W'(lacks(want_depth, s1.has_depth))
            + MISS_W'(lacks(want_stencil, s1.has_stencil))
            + MISS_W'(lacks(want_samples, s1.has_samples));

    color_sum = 16'(sq_term(want_red, s1.has_red))
              + 16'(sq_term(want_green, s1.has_green))
              + 16'(sq_term(want_blue, s1.has_blue));
    extra_sum = 17'(sq_term(want_alpha, s1.has_alpha))
              + 17'(sq_term(want_depth, s1.has_depth))
              + 17'(sq_term(want_stencil, s1.has_stencil))
              + 17'(sq_term(want_samples, s1.has_samples));

    // saturate out-of-range scores
    color = (color_sum > 16'(COLOR_MAX)) ? COLOR_MAX : color_sum[COLOR_W-1:0];
    extra = (extra_sum > 17'(EXTRA_MAX)) ? EXTRA_MAX : extra_sum[EXTRA_W-1:0];

    // strict improvement only, earlier candidate wins ties
    better = !have_best
          || (missing < fewest_missing_count)
          || ((missing == fewest_missing_count)
              && ((color < least_color_score)
                  || ((color == least_color_score) && (extra < least_extra_score))));
    take = eligible && better;

    have_best_next            = have_best || take;
    best_position_next        = take ? item_position[POS_W-1:0] : best_position;
    fewest_missing_count_next = take ? missing : fewest_missing_count;
    least_color_score_next    = take ? color : least_color_score;
    least_extra_score_next    = take ? extra : least_extra_score;

    pos_wide = {{IDX_W{1'b0}}, best_position_next};
  end

  // search state; cleared once the last candidate is reported
  always_ff @(posedge clk) begin
    if (rst) begin
      item_position <= '0;
      have_best     <= 1'b0;
    end else if (s1_go) begin
      if (s1.last_candidate) begin
        item_position <= '0;
        have_best     <= 1'b0;
      end else begin
        if (in_range) begin
          item_position <= item_position + 1'b1;
        end
        have_best <= have_best_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      best_position        <= best_position_next;
      fewest_missing_count <= fewest_missing_count_next;
      least_color_score    <= least_color_score_next;
      least_extra_score    <= least_extra_score_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1.last_candidate) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // all fields read zero when nothing matched
  always_ff @(posedge clk) begin
    if (s1_go && s1.last_candidate) begin
      out_found   <= have_best_next;
      out_index   <= have_best_next ? pos_wide[IDX_W-1:0] : '0;
      out_missing <= have_best_next ? fewest_missing_count_next : '0;
      out_color   <= have_best_next ? least_color_score_next : '0;
      out_extra   <= have_best_next ? least_extra_score_next : '0;
    end
  end

  assign result.valid            = out_valid;
  assign result.found            = out_found;
  assign result.best_index       = out_index;
  assign result.best_missing     = out_missing;
  assign result.best_color_score = out_color;
  assign result.best_extra_score = out_extra;

endmodule

`default_nettype wire

### sim/tb.sv
`timescale 1ns / 1ps
// testbench for the best match config selector: directed and random candidate lists
module tb;
  import bmcs_pkg::*;

  localparam int LIST_CAP       = 256;   // positions at or above this are ignored
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moving on any channel
  localparam int DRAIN_CYCLES   = 4;     // extra wait after every queued result is taken
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_ITEMS    = 140;   // scored candidates per random phase
  localparam int REPORT_LIMIT   = 10;

  // how the desired channel registers are drawn in a random phase
  typedef enum {WANT_TYPICAL, WANT_FULL, WANT_TOP, WANT_NONE} want_mode_t;

  // one result word as the checker sees it
  typedef struct packed {
    logic               found;
    logic [IDX_W-1:0]   index;
    logic [MISS_W-1:0]  missing;
    logic [COLOR_W-1:0] color;
    logic [EXTRA_W-1:0] extra;
  } verdict_t;

  logic clk = 1'b0;
  logic rst;

  bmcs_cand_if   cand_ch ();
  bmcs_result_if res_ch ();
  bmcs_cfg_if    cfg_ch ();

  best_match_config_selector dut (
    .clk    (clk),
    .rst    (rst),
    .cand   (cand_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  // mirror of the desired configuration, updated as each register write lands
  bit                       want_double = 1'b1;
  logic signed [WANT_W-1:0] want_chan [REG_WANT_RED:REG_WANT_SAMPLES] =
    '{default: DONT_CARE};

  // mirror of the running search over the current list
  int list_pos       = 0;
  bit have_best      = 1'b0;
  int best_pos       = 0;
  int fewest_missing = 0;
  int least_color    = 0;
  int least_extra    = 0;

  verdict_t pending_verdicts [$];
  int       error_count  = 0;
  int       quiet_cycles = 0;

  // idling switches, flipped per list by the random test
  bit sender_gaps     = 1'b1;
  bit receiver_stalls = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // squared distance of one channel, zero when the register says don't care;
  // any other negative register value is scored like a plain number
  function automatic int squared_gap(logic signed [WANT_W-1:0] want,
                                     logic [CHAN_W-1:0] have);
    int d;
    if (want == DONT_CARE) return 0;
    d = int'(want) - int'(have);
    return d * d;
  endfunction

  // a requested buffer (register above zero) that the candidate lacks
  function automatic int lacks_buffer(logic signed [WANT_W-1:0] want,
                                      logic [CHAN_W-1:0] have);
    return (want > 0 && have == 0) ? 1 : 0;
  endfunction

  // fold one accepted candidate into the running best; a last word queues the
  // expected result and clears the search
  function automatic void rank_candidate(cand_t w);
    int       miss;
    int       color;
    int       extra;
    bit       better;
    verdict_t v;
    // past the list capacity nothing is scored and the position sticks
    if (list_pos < LIST_CAP) begin
      if (w.has_double_buffer == want_double) begin
        miss = lacks_buffer(want_chan[REG_WANT_ALPHA], w.has_alpha)
             + lacks_buffer(want_chan[REG_WANT_DEPTH], w.has_depth)
             + lacks_buffer(want_chan[REG_WANT_STENCIL], w.has_stencil)
             + lacks_buffer(want_chan[REG_WANT_SAMPLES], w.has_samples);
        color = squared_gap(want_chan[REG_WANT_RED], w.has_red)
              + squared_gap(want_chan[REG_WANT_GREEN], w.has_green)
              + squared_gap(want_chan[REG_WANT_BLUE], w.has_blue);
        extra = squared_gap(want_chan[REG_WANT_ALPHA], w.has_alpha)
              + squared_gap(want_chan[REG_WANT_DEPTH], w.has_depth)
              + squared_gap(want_chan[REG_WANT_STENCIL], w.has_stencil)
              + squared_gap(want_chan[REG_WANT_SAMPLES], w.has_samples);
        // scores saturate, and the saturated value is what gets compared
        if (color > int'(COLOR_MAX)) color = int'(COLOR_MAX);
        if (extra > int'(EXTRA_MAX)) extra = int'(EXTRA_MAX);
        // lexicographic on (missing, color, extra); ties keep the earlier one
        if (!have_best || miss < fewest_missing) better = 1'b1;
        else if (miss == fewest_missing)
          better = (color < least_color) || (color == least_color && extra < least_extra);
        else better = 1'b0;
        if (better) begin
          have_best      = 1'b1;
          best_pos       = list_pos;
          fewest_missing = miss;
          least_color    = color;
          least_extra    = extra;
        end
      end
      list_pos++;
    end
    if (w.last_candidate) begin
      // nothing found reports all zeros
      v = '0;
      if (have_best) begin
        v.found   = 1'b1;
        v.index   = best_pos[IDX_W-1:0];
        v.missing = fewest_missing[MISS_W-1:0];
        v.color   = least_color[COLOR_W-1:0];
        v.extra   = least_extra[EXTRA_W-1:0];
      end
      pending_verdicts.push_back(v);
      list_pos       = 0;
      have_best      = 1'b0;
      best_pos       = 0;
      fewest_missing = 0;
      least_color    = 0;
      least_extra    = 0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // send one candidate word, with an optional gap in front of it
  task automatic send_candidate(cand_t w);
    @(negedge clk);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      cand_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    cand_ch.valid             <= 1'b1;
    cand_ch.has_double_buffer <= w.has_double_buffer;
    cand_ch.has_red           <= w.has_red;
    cand_ch.has_green         <= w.has_green;
    cand_ch.has_blue          <= w.has_blue;
    cand_ch.has_alpha         <= w.has_alpha;
    cand_ch.has_depth         <= w.has_depth;
    cand_ch.has_stencil       <= w.has_stencil;
    cand_ch.has_samples       <= w.has_samples;
    cand_ch.last_candidate    <= w.last_candidate;
    do @(posedge clk); while (!cand_ch.ready);
    rank_candidate(w);
  endtask

  // stop sending, wait for every queued result, then let the pipe empty
  task automatic drain_block();
    @(negedge clk);
    cand_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one register write; leaves valid high so writes can go back to back
  task automatic program_register(logic [CFG_IDX_W-1:0] idx, logic [WANT_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == REG_WANT_DOUBLE_BUFFER) want_double = value[0];
    else want_chan[idx] = value;
  endtask

  // write the whole desired configuration; only called with the block idle
  task automatic apply_settings(bit dbl, int red, int green, int blue, int alpha,
                                int depth, int stencil, int samples);
    program_register(REG_WANT_DOUBLE_BUFFER, {{(WANT_W-1){1'b0}}, dbl});
    program_register(REG_WANT_RED,     red[WANT_W-1:0]);
    program_register(REG_WANT_GREEN,   green[WANT_W-1:0]);
    program_register(REG_WANT_BLUE,    blue[WANT_W-1:0]);
    program_register(REG_WANT_ALPHA,   alpha[WANT_W-1:0]);
    program_register(REG_WANT_DEPTH,   depth[WANT_W-1:0]);
    program_register(REG_WANT_STENCIL, stencil[WANT_W-1:0]);
    program_register(REG_WANT_SAMPLES, samples[WANT_W-1:0]);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic cand_t candidate(bit dbl, int red, int green, int blue, int alpha,
                                      int depth, int stencil, int samples, bit last);
    cand_t w;
    w.has_double_buffer = dbl;
    w.has_red           = red[CHAN_W-1:0];
    w.has_green         = green[CHAN_W-1:0];
    w.has_blue          = blue[CHAN_W-1:0];
    w.has_alpha         = alpha[CHAN_W-1:0];
    w.has_depth         = depth[CHAN_W-1:0];
    w.has_stencil       = stencil[CHAN_W-1:0];
    w.has_samples       = samples[CHAN_W-1:0];
    w.last_candidate    = last;
    return w;
  endfunction

  // mostly in the nominal 0..32 range, sometimes absent, sometimes above it
  function automatic logic [CHAN_W-1:0] rand_channel();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CHAN_W'($urandom_range(33, 63));
      default: return CHAN_W'($urandom_range(0, 32));
    endcase
  endfunction

  function automatic int rand_want(want_mode_t mode);
    case (mode)
      WANT_FULL: return $urandom_range(0, 127) - 64;
      WANT_TOP:  return 32;
      WANT_NONE: return int'(DONT_CARE);
      default:   return ($urandom_range(0, 3) == 0) ? int'(DONT_CARE) : $urandom_range(0, 32);
    endcase
  endfunction

  // a quarter of the candidates carry the wrong flag and are skipped
  function automatic cand_t rand_candidate(bit last);
    cand_t w;
    w.has_double_buffer = ($urandom_range(0, 3) == 0) ? !want_double : want_double;
    w.has_red           = rand_channel();
    w.has_green         = rand_channel();
    w.has_blue          = rand_channel();
    w.has_alpha         = rand_channel();
    w.has_depth         = rand_channel();
    w.has_stencil       = rand_channel();
    w.has_samples       = rand_channel();
    w.last_candidate    = last;
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random stall bursts, checking, watchdog
  // ---------------------------------------------------------------------------

  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (receiver_stalls && $urandom_range(0, 3) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    verdict_t got;
    verdict_t exp_v;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got.found   = res_ch.found;
      got.index   = res_ch.best_index;
      got.missing = res_ch.best_missing;
      got.color   = res_ch.best_color_score;
      got.extra   = res_ch.best_extra_score;
      if (pending_verdicts.size() == 0) begin
        // a result word with no list closed to account for it
        error_count++;
        if (error_count <= REPORT_LIMIT)
          $display("unexpected result: found=%0d index=%0d missing=%0d color=%0d extra=%0d",
                   got.found, got.index, got.missing, got.color, got.extra);
      end else begin
        exp_v = pending_verdicts.pop_front();
        if (got !== exp_v) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display("mismatch: exp found=%0d index=%0d missing=%0d color=%0d extra=%0d, got found=%0d index=%0d missing=%0d color=%0d extra=%0d",
                     exp_v.found, exp_v.index, exp_v.missing, exp_v.color, exp_v.extra,
                     got.found, got.index, got.missing, got.color, got.extra);
        end
      end
    end
  end

  // any word moving on any channel counts as progress
  always @(posedge clk) begin
    if (rst || (cand_ch.valid && cand_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles <= 0;
    else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset configuration: flag 1, every channel don't care, so every matching
  // candidate scores zero and the first one wins
  task automatic test_defaults();
    send_candidate(candidate(0, 1, 2, 3, 4, 5, 6, 7, 0));          // skipped on flag
    send_candidate(candidate(1, 8, 8, 8, 0, 0, 0, 0, 0));          // first match wins
    send_candidate(candidate(1, 32, 32, 32, 32, 32, 32, 32, 1));   // tie, ignored
    send_candidate(candidate(0, 5, 5, 5, 5, 5, 5, 5, 1));          // nothing found
    send_candidate(candidate(1, 0, 0, 0, 0, 0, 0, 0, 1));          // single-word list
    drain_block();
  endtask

  // register and field extremes, saturation, each ranking key deciding
  task automatic test_scoring_extremes();
    // blue at -64 is a real target, not don't care
    apply_settings(0, 32, 0, -64, 32, 1, 63, -1);
    send_candidate(candidate(0, 0, 0, 0, 0, 0, 0, 0, 0));          // three missing, color saturates
    send_candidate(candidate(0, 63, 63, 63, 63, 63, 63, 63, 0));   // fewer missing wins
    send_candidate(candidate(1, 32, 0, 0, 32, 1, 63, 0, 0));       // wrong flag
    send_candidate(candidate(0, 32, 0, 0, 32, 1, 63, 0, 0));       // same color, lower extra
    send_candidate(candidate(0, 32, 0, 0, 32, 1, 63, 0, 1));       // exact tie keeps earlier
    drain_block();

    apply_settings(1, 63, 63, 63, 63, 63, 63, 63);
    send_candidate(candidate(1, 0, 0, 0, 0, 0, 0, 0, 0));          // all four buffers missing
    send_candidate(candidate(1, 63, 63, 63, 0, 0, 0, 0, 0));       // same missing, lower color
    send_candidate(candidate(1, 32, 32, 32, 32, 32, 32, 32, 0));   // nothing missing
    send_candidate(candidate(1, 63, 63, 63, 63, 63, 63, 63, 1));   // perfect match
    drain_block();

    // most negative targets against the widest fields saturate both scores
    apply_settings(1, -64, -64, -64, -64, -64, -64, -64);
    send_candidate(candidate(1, 63, 63, 63, 63, 63, 63, 63, 1));
    drain_block();
  endtask

  // a list longer than the capacity: the better candidate past it is ignored,
  // and the last mark beyond it still reports and clears
  task automatic test_list_overflow();
    cand_t w;
    apply_settings(1, 10, -1, -1, -1, -1, -1, -1);
    for (int i = 0; i < LIST_CAP + 44; i++) begin
      w = rand_candidate(i == LIST_CAP + 43);
      w.has_double_buffer = 1'b1;
      w.has_red = (i == LIST_CAP - 1) ? CHAN_W'(5) : (i == LIST_CAP + 14) ? CHAN_W'(10) : '0;
      send_candidate(w);
    end
    send_candidate(candidate(1, 10, 0, 0, 0, 0, 0, 0, 1));         // fresh list after the clear
    drain_block();
  endtask

  // random lists under a series of configurations; the last phase runs without
  // idling on either side
  task automatic test_random_lists();
    want_mode_t mode;
    bit         dbl;
    bit         quiet;
    int         scored;
    int         len;
    cand_t      w;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       begin mode = WANT_TYPICAL; dbl = 1'b1; end
        1:       begin mode = WANT_FULL;    dbl = 1'b0; end
        2:       begin mode = WANT_TOP;     dbl = 1'b1; end
        3:       begin mode = WANT_NONE;    dbl = 1'b0; end
        4:       begin mode = WANT_FULL;    dbl = 1'($urandom_range(0, 1)); end
        default: begin mode = WANT_TYPICAL; dbl = 1'($urandom_range(0, 1)); end
      endcase
      apply_settings(dbl, rand_want(mode), rand_want(mode), rand_want(mode), rand_want(mode),
                     rand_want(mode), rand_want(mode), rand_want(mode));
      scored = 0;
      while (scored < PHASE_ITEMS) begin
        // some lists run with no idling at all
        quiet = (phase == RANDOM_PHASES - 1) || ($urandom_range(0, 3) == 0);
        sender_gaps     = !quiet;
        receiver_stalls = !quiet;
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
        for (int k = 0; k < len; k++) begin
          w = rand_candidate(k == len - 1);
          if (w.has_double_buffer == want_double) scored++;
          send_candidate(w);
        end
      end
      drain_block();
    end
  endtask

  initial begin
    rst                       = 1'b1;
    cand_ch.valid             = 1'b0;
    cand_ch.has_double_buffer = 1'b0;
    cand_ch.has_red           = '0;
    cand_ch.has_green         = '0;
    cand_ch.has_blue          = '0;
    cand_ch.has_alpha         = '0;
    cand_ch.has_depth         = '0;
    cand_ch.has_stencil       = '0;
    cand_ch.has_samples       = '0;
    cand_ch.last_candidate    = 1'b0;
    cfg_ch.valid              = 1'b0;
    cfg_ch.index              = REG_WANT_DOUBLE_BUFFER;
    cfg_ch.data               = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_defaults();
    test_scoring_extremes();
    test_list_overflow();
    test_random_lists();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule
